FILE: rtl/core/ogot_pkg.sv
// Shared types, codes and constants for the run-once guard unit.
// Used by ogot_ctrl, ogot_dp and once_guard_owner_table; depends on nothing.
package ogot_pkg;

    localparam int unsigned GUARDS_DEFAULT      = 256;
    localparam int unsigned TABLE_DEPTH_DEFAULT = 32;

    localparam int unsigned GUARD_ID_W    = 8;
    localparam int unsigned GUARD_ID_SPAN = 256;
    localparam int unsigned THREAD_ID_W   = 32;
    localparam int unsigned VERDICT_W     = 3;
    localparam int unsigned COUNT_W       = 6;

    typedef logic [VERDICT_W-1:0] verdict_t;

    localparam verdict_t V_DONE      = 3'd0;
    localparam verdict_t V_RUN       = 3'd1;
    localparam verdict_t V_REENTRANT = 3'd2;
    localparam verdict_t V_WAIT      = 3'd3;
    localparam verdict_t V_IGNORED   = 3'd4;
    localparam verdict_t V_FINISHED  = 3'd5;

    typedef logic [1:0] gflag_t;

    localparam gflag_t GF_UNTOUCHED = 2'd0;
    localparam gflag_t GF_IN_FLIGHT = 2'd1;
    localparam gflag_t GF_COMPLETE  = 2'd2;

    localparam logic ACT_ENTER  = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    typedef struct packed {
        logic                   action;
        logic                   guard_present;
        logic [GUARD_ID_W-1:0]  guard_id;
        logic [THREAD_ID_W-1:0] thread_id;
    } req_t;

    typedef struct packed {
        verdict_t               verdict;
        logic                   claim_unrecorded;
        logic [COUNT_W-1:0]     in_flight_count;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     take;
        logic     gwr;
        gflag_t   gval;
        logic     append;
        logic     scan_rd;
        logic     idx_inc;
        logic     count_dec;
        logic     move_rd;
        logic     move_wr;
        logic     load_out;
        verdict_t verdict;
        logic     unrec;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic   action;
        logic   present;
        gflag_t gflag;
        logic   table_full;
        logic   idx_at_end;
        logic   guard_match;
        logic   owner_match;
        logic   out_busy;
    } sts_t;

    typedef logic [GUARD_ID_SPAN-1:0][GUARD_ID_W-1:0] wrap_tbl_t;

    // Guard index wrap table, built by counting so no divider is needed.
    function automatic wrap_tbl_t build_wrap(input int unsigned guards);
        wrap_tbl_t   tbl;
        int unsigned r;
        r = 0;
        for (int unsigned i = 0; i < GUARD_ID_SPAN; i++)
        begin
            tbl[i] = GUARD_ID_W'(r);
            r = r + 1;
            if (r == guards)
            begin
                r = 0;
            end
        end
        return tbl;
    endfunction

endpackage

FILE: rtl/core/ogot_ctrl.sv
// Sequencer of the run-once guard unit: one request at a time.
// Depends on ogot_pkg; drives ogot_dp through cmd_t and reads sts_t.
module ogot_ctrl
    import ogot_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_LOOK     = 3'd1;
    localparam logic [2:0] S_SCAN_RD  = 3'd2;
    localparam logic [2:0] S_SCAN_CMP = 3'd3;
    localparam logic [2:0] S_MOVE_RD  = 3'd4;
    localparam logic [2:0] S_MOVE_WR  = 3'd5;
    localparam logic [2:0] S_RESP     = 3'd6;

    logic [2:0] state_reg, state_next;
    verdict_t   verdict_reg, verdict_next;
    logic       unrec_reg, unrec_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            verdict_reg <= V_IGNORED;
            unrec_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            verdict_reg <= verdict_next;
            unrec_reg   <= unrec_next;
        end
    end

    always_comb
    begin
        cmd          = '0;
        req_ready    = 1'b0;
        state_next   = state_reg;
        verdict_next = verdict_reg;
        unrec_next   = unrec_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                unrec_next = 1'b0;
                if (!sts.present)
                begin
                    verdict_next = V_IGNORED;
                    state_next   = S_RESP;
                end
                else if (sts.action == ACT_ENTER)
                begin
                    case (sts.gflag)
                        GF_COMPLETE:
                        begin
                            verdict_next = V_DONE;
                            state_next   = S_RESP;
                        end
                        GF_UNTOUCHED:
                        begin
                            cmd.gwr  = 1'b1;
                            cmd.gval = GF_IN_FLIGHT;
                            if (sts.table_full)
                            begin
                                unrec_next = 1'b1;
                            end
                            else
                            begin
                                cmd.append = 1'b1;
                            end
                            verdict_next = V_RUN;
                            state_next   = S_RESP;
                        end
                        default:
                        begin
                            // In flight, or the unused flag code: look for our claim.
                            state_next = S_SCAN_RD;
                        end
                    endcase
                end
                else
                begin
                    cmd.gwr    = 1'b1;
                    cmd.gval   = GF_COMPLETE;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (sts.idx_at_end)
                begin
                    verdict_next = (sts.action == ACT_FINISH) ? V_FINISHED : V_WAIT;
                    state_next   = S_RESP;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (sts.action == ACT_FINISH && sts.guard_match)
                begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_MOVE_RD;
                end
                else if (sts.action == ACT_ENTER && sts.guard_match && sts.owner_match)
                begin
                    verdict_next = V_REENTRANT;
                    state_next   = S_RESP;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_MOVE_RD:
            begin
                cmd.move_rd = 1'b1;
                state_next  = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                cmd.move_wr  = 1'b1;
                verdict_next = V_FINISHED;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    cmd.verdict  = verdict_reg;
                    cmd.unrec    = unrec_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/ogot_dp.sv
// Datapath of the run-once guard unit: guard flag memory, claim table,
// request and response registers. Depends on ogot_pkg; driven by ogot_ctrl.
module ogot_dp
    import ogot_pkg::*;
#(
    parameter int unsigned GUARDS      = GUARDS_DEFAULT,
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // Only the first GUARD_ID_SPAN guards can ever be addressed.
    localparam int unsigned GDEPTH = (GUARDS < GUARD_ID_SPAN) ? GUARDS : GUARD_ID_SPAN;
    localparam int unsigned GIW    = $clog2(GDEPTH);
    localparam int unsigned AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW     = $clog2(TABLE_DEPTH + 1);

    localparam wrap_tbl_t WRAP_TBL = build_wrap(GUARDS);

    logic [GIW-1:0]         gidx_in;
    req_t                   item_reg;
    logic [GIW-1:0]         gidx_reg;
    gflag_t                 gflag_rd_reg;
    logic                   gvalid_rd_reg;
    logic [GDEPTH-1:0]      gvalid_reg;
    gflag_t                 gmem [GDEPTH];

    logic [GIW-1:0]         cg_mem [TABLE_DEPTH];
    logic [THREAD_ID_W-1:0] co_mem [TABLE_DEPTH];
    logic [GIW-1:0]         cg_rd_reg;
    logic [THREAD_ID_W-1:0] co_rd_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          idx_reg;

    logic                   c_we;
    logic [AW-1:0]          c_waddr;
    logic [GIW-1:0]         c_wguard;
    logic [THREAD_ID_W-1:0] c_wowner;
    logic                   c_re;
    logic [AW-1:0]          c_raddr;

    rsp_t                   out_reg;
    logic                   out_valid_reg;

    assign gidx_in = WRAP_TBL[req.guard_id][GIW-1:0];

    // Request capture and guard flag read.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            item_reg      <= req;
            gidx_reg      <= gidx_in;
            gflag_rd_reg  <= gmem[gidx_in];
            gvalid_rd_reg <= gvalid_reg[gidx_in];
        end
        if (cmd.gwr)
        begin
            gmem[gidx_reg] <= cmd.gval;
        end
    end

    // An entry that was never written since reset reads as untouched.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gvalid_reg <= '0;
        end
        else if (cmd.gwr)
        begin
            gvalid_reg[gidx_reg] <= 1'b1;
        end
    end

    // Claim table ports.
    assign c_we     = cmd.append | cmd.move_wr;
    assign c_waddr  = cmd.append ? count_reg[AW-1:0] : idx_reg[AW-1:0];
    assign c_wguard = cmd.append ? gidx_reg : cg_rd_reg;
    assign c_wowner = cmd.append ? item_reg.thread_id : co_rd_reg;
    assign c_re     = cmd.scan_rd | cmd.move_rd;
    assign c_raddr  = cmd.move_rd ? count_reg[AW-1:0] : idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            cg_mem[c_waddr] <= c_wguard;
            co_mem[c_waddr] <= c_wowner;
        end
        if (c_re)
        begin
            cg_rd_reg <= cg_mem[c_raddr];
            co_rd_reg <= co_mem[c_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.append)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.count_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.take)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.verdict          <= cmd.verdict;
            out_reg.claim_unrecorded <= cmd.unrec;
            out_reg.in_flight_count  <= COUNT_W'(count_reg);
        end
    end

    assign sts.action      = item_reg.action;
    assign sts.present     = item_reg.guard_present;
    assign sts.gflag       = gvalid_rd_reg ? gflag_rd_reg : GF_UNTOUCHED;
    assign sts.table_full  = (count_reg == CW'(TABLE_DEPTH));
    assign sts.idx_at_end  = (idx_reg >= count_reg);
    assign sts.guard_match = (cg_rd_reg == gidx_reg);
    assign sts.owner_match = (co_rd_reg == item_reg.thread_id);
    assign sts.out_busy    = out_valid_reg & ~rsp_ready;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

FILE: rtl/core/once_guard_owner_table.sv
// Top level of the run-once guard unit with its in-flight owner table.
// Depends on ogot_pkg, ogot_ctrl and ogot_dp.
//
//   Channel   Direction  Handshake               Beat type
//   req       in         req_valid / req_ready   req_t (action, guard, thread)
//   rsp       out        rsp_valid / rsp_ready   rsp_t (verdict, unrecorded, count)
//
// One request is worked at a time. Ignored, done and fresh-claim requests pass through
// S_IDLE, S_LOOK and S_RESP. A table search reads and compares each entry in S_SCAN_RD
// and S_SCAN_CMP, seeing the end in S_SCAN_RD when none hits; a finish that hits then
// reads the last entry and writes it into the freed place. Reset clears the guard flags
// at once through one valid bit per flag. A response waits in the output register while
// the next request is accepted; the sequencer holds only if a second one is then ready.
module once_guard_owner_table
    import ogot_pkg::*;
#(
    parameter int unsigned GUARDS      = GUARDS_DEFAULT,
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // Command and status groups between the sequencer and the datapath.
    cmd_t cmd;
    sts_t sts;

    ogot_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The datapath holds the guard flags, the claim table and the
    // response register, and sees the request payload directly.
    ogot_dp #(
        .GUARDS      (GUARDS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the run-once guard unit with its owner table.
// Depends on ogot_pkg and once_guard_owner_table, and through it on ogot_ctrl and ogot_dp.
module tb_top;
    import ogot_pkg::*;

    localparam int unsigned NGUARD      = GUARDS_DEFAULT;
    localparam int unsigned TDEPTH      = TABLE_DEPTH_DEFAULT;
    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned TAIL_CYCLES = 100;
    localparam int unsigned RANDOM_BEATS = 1650;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    once_guard_owner_table u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Request beats waiting to be driven, and the responses owed for beats
    // already accepted, oldest first.
    req_t req_backlog[$];
    rsp_t verdicts_due[$];
    rsp_t due_head;

    int unsigned send_idle  = 25;
    int unsigned recv_idle  = 57;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    // Our own picture of the unit: guard flags, the claim table and its fill.
    gflag_t                 flag_mem [NGUARD];
    logic [GUARD_ID_W-1:0]  tab_guard [TDEPTH];
    logic [THREAD_ID_W-1:0] tab_owner [TDEPTH];
    int unsigned            tab_fill = 0;

    // A lighter picture kept by the stimulus side so that it can aim its
    // requests: which guards are untouched, and which are live with which owner.
    gflag_t      gen_flag [NGUARD];
    int unsigned untouched_left;
    int unsigned live_guard[$];
    logic [31:0] live_owner[$];
    int unsigned items_left;

    // Works out the response to one accepted request beat and moves the
    // guard flags and the claim table on as the unit should.
    function automatic rsp_t judge_beat(input req_t r);
        rsp_t        o;
        int unsigned g;
        bit          hit;
        o         = '0;
        o.verdict = V_IGNORED;
        hit       = 1'b0;
        g         = r.guard_id % NGUARD;
        if (r.guard_present)
        begin
            if (r.action == ACT_ENTER)
            begin
                if (flag_mem[g] == GF_COMPLETE)
                begin
                    o.verdict = V_DONE;
                end
                else if (flag_mem[g] == GF_UNTOUCHED)
                begin
                    // A fresh claim is granted even when the table is full; it
                    // just goes unrecorded, so the owner cannot re-enter later.
                    flag_mem[g] = GF_IN_FLIGHT;
                    o.verdict   = V_RUN;
                    if (tab_fill < TDEPTH)
                    begin
                        tab_guard[tab_fill] = GUARD_ID_W'(g);
                        tab_owner[tab_fill] = r.thread_id;
                        tab_fill++;
                    end
                    else
                    begin
                        o.claim_unrecorded = 1'b1;
                    end
                end
                else
                begin
                    o.verdict = V_WAIT;
                    for (int unsigned k = 0; k < tab_fill; k++)
                    begin
                        if (tab_guard[k] == GUARD_ID_W'(g) && tab_owner[k] == r.thread_id)
                        begin
                            o.verdict = V_REENTRANT;
                        end
                    end
                end
            end
            else
            begin
                // Finish completes the guard from any state and frees the first
                // claim naming it by pulling the last entry into its slot.
                flag_mem[g] = GF_COMPLETE;
                o.verdict   = V_FINISHED;
                for (int unsigned k = 0; k < tab_fill; k++)
                begin
                    if (!hit && tab_guard[k] == GUARD_ID_W'(g))
                    begin
                        hit          = 1'b1;
                        tab_fill--;
                        tab_guard[k] = tab_guard[tab_fill];
                        tab_owner[k] = tab_owner[tab_fill];
                    end
                end
            end
        end
        o.in_flight_count = COUNT_W'(tab_fill);
        return o;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Driver. A new beat is offered only once the previous one has gone, so
    // valid and the payload hold steady while the unit stalls. The beat that
    // is accepted at this edge is judged right here, in acceptance order.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                verdicts_due.push_back(judge_beat(req));
            end
            if (!req_valid || req_ready)
            begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    req       <= req_backlog.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Each response beat is held against the oldest owed response,
    // field by field; ready is redrawn every cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    report_mismatch("response with nothing owed", 64'(rsp), 64'(0));
                end
                else
                begin
                    due_head = verdicts_due.pop_front();
                    if (rsp.verdict !== due_head.verdict)
                    begin
                        report_mismatch("verdict", 64'(rsp.verdict), 64'(due_head.verdict));
                    end
                    if (rsp.claim_unrecorded !== due_head.claim_unrecorded)
                    begin
                        report_mismatch("claim_unrecorded", 64'(rsp.claim_unrecorded),
                                        64'(due_head.claim_unrecorded));
                    end
                    if (rsp.in_flight_count !== due_head.in_flight_count)
                    begin
                        report_mismatch("in_flight_count", 64'(rsp.in_flight_count),
                                        64'(due_head.in_flight_count));
                    end
                end
            end
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Watchdog: too long without a beat on either channel ends the run.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("once_guard_owner_table: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Queues one request beat and keeps the stimulus-side picture current.
    task automatic queue_req(input logic act, input logic present, input int unsigned g,
                             input logic [31:0] t);
        req_t r;
        int   idx;
        r.action        = act;
        r.guard_present = present;
        r.guard_id      = GUARD_ID_W'(g);
        r.thread_id     = t;
        idx             = -1;
        req_backlog.push_back(r);
        if (present)
        begin
            if (act == ACT_ENTER)
            begin
                if (gen_flag[g] == GF_UNTOUCHED)
                begin
                    gen_flag[g] = GF_IN_FLIGHT;
                    untouched_left--;
                    live_guard.push_back(g);
                    live_owner.push_back(t);
                end
            end
            else
            begin
                if (gen_flag[g] == GF_UNTOUCHED)
                begin
                    untouched_left--;
                end
                gen_flag[g] = GF_COMPLETE;
                for (int k = 0; k < live_guard.size(); k++)
                begin
                    if (idx < 0 && live_guard[k] == g)
                    begin
                        idx = k;
                    end
                end
                if (idx >= 0)
                begin
                    live_guard.delete(idx);
                    live_owner.delete(idx);
                end
            end
        end
    endtask

    // Only called while some guard is still untouched.
    function automatic int unsigned pick_untouched();
        int unsigned g;
        g = $urandom_range(0, NGUARD - 1);
        while (gen_flag[g] != GF_UNTOUCHED)
        begin
            g = (g + 1) % NGUARD;
        end
        return g;
    endfunction

    // Returns a completed guard, or -1 when none is complete yet.
    function automatic int pick_complete();
        int unsigned start;
        int          found;
        start = $urandom_range(0, NGUARD - 1);
        found = -1;
        for (int unsigned i = 0; i < NGUARD; i++)
        begin
            if (found < 0 && gen_flag[(start + i) % NGUARD] == GF_COMPLETE)
            begin
                found = int'((start + i) % NGUARD);
            end
        end
        return found;
    endfunction

    task automatic drain_wait();
        while (req_backlog.size() != 0 || req_valid || verdicts_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One random beat. Guards can be claimed only once per run, so fresh
    // claims are rationed against the beats still to come; most other beats
    // probe or finish live claims, which is where the table is exercised.
    task automatic random_beat(output bit counted);
        int unsigned roll;
        int unsigned k;
        int          c;
        counted = 1'b1;
        roll    = $urandom_range(0, 99);
        if (untouched_left > 0 && $urandom_range(0, items_left) < 2 * untouched_left)
        begin
            queue_req(ACT_ENTER, 1'b1, pick_untouched(), $urandom);
        end
        else if (roll < 45 && live_guard.size() != 0)
        begin
            k = $urandom_range(0, live_guard.size() - 1);
            if (roll < 28)
            begin
                queue_req(ACT_ENTER, 1'b1, live_guard[k], live_owner[k]);
            end
            else
            begin
                queue_req(ACT_ENTER, 1'b1, live_guard[k], live_owner[k] ^ ($urandom | 32'h1));
            end
        end
        else if (roll < 65 && live_guard.size() != 0)
        begin
            k = $urandom_range(0, live_guard.size() - 1);
            queue_req(ACT_FINISH, 1'b1, live_guard[k], $urandom);
        end
        else if (roll < 85)
        begin
            c = pick_complete();
            if (c >= 0)
            begin
                queue_req((roll < 77) ? ACT_ENTER : ACT_FINISH, 1'b1, c, $urandom);
            end
            else
            begin
                queue_req(ACT_ENTER, 1'b0, $urandom_range(0, 255), $urandom);
                counted = 1'b0;
            end
        end
        else if (roll < 93)
        begin
            queue_req(1'($urandom_range(0, 1)), 1'b0, $urandom_range(0, 255), $urandom);
            counted = 1'b0;
        end
        else
        begin
            queue_req(1'($urandom_range(0, 1)), 1'b1, $urandom_range(0, 255), $urandom);
        end
    endtask

    task automatic run_phase(input int unsigned quota, input int unsigned s_idle,
                             input int unsigned r_idle, input bit hold_off);
        int unsigned done_n;
        bit          counted;
        send_idle = s_idle;
        recv_idle = r_idle;
        done_n    = 0;
        while (done_n < quota)
        begin
            random_beat(counted);
            if (counted)
            begin
                done_n++;
                if (items_left > 0)
                begin
                    items_left--;
                end
                // Sender holds off once mid-phase until every owed response is in.
                if (hold_off && done_n == quota / 2)
                begin
                    drain_wait();
                end
            end
        end
    endtask

    // Fill the claim table past its depth, so that the last claims go
    // unrecorded; the owner of an unrecorded claim is then told to wait, and
    // finishing it frees nothing.
    task automatic flood_table();
        int unsigned last_g;
        logic [31:0] last_t;
        for (int unsigned i = 0; i < TDEPTH + 2; i++)
        begin
            if (untouched_left > 0)
            begin
                queue_req(ACT_ENTER, 1'b1, pick_untouched(), $urandom);
            end
        end
        last_g = live_guard[live_guard.size() - 1];
        last_t = live_owner[live_owner.size() - 1];
        queue_req(ACT_ENTER, 1'b1, last_g, last_t);
        queue_req(ACT_FINISH, 1'b1, last_g, last_t);
    endtask

    initial
    begin
        for (int unsigned i = 0; i < NGUARD; i++)
        begin
            flag_mem[i] = GF_UNTOUCHED;
            gen_flag[i] = GF_UNTOUCHED;
        end
        untouched_left = NGUARD;
        items_left     = RANDOM_BEATS;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: requests without a guard, claim, re-entry by the
        // owner, a second thread told to wait, extreme guards and threads,
        // finish freeing the first entry so that the last one moves, finish on
        // an untouched guard, finish repeated on a complete guard, and done.
        queue_req(ACT_ENTER,  1'b0, 0,   32'hFFFF_FFFF);
        queue_req(ACT_FINISH, 1'b0, 255, 32'h0000_0000);
        queue_req(ACT_ENTER,  1'b1, 0,   32'h0000_0000);
        queue_req(ACT_ENTER,  1'b1, 0,   32'h0000_0000);
        queue_req(ACT_ENTER,  1'b1, 0,   32'hFFFF_FFFF);
        queue_req(ACT_ENTER,  1'b1, 255, 32'hFFFF_FFFF);
        queue_req(ACT_ENTER,  1'b1, 255, 32'hFFFF_FFFF);
        queue_req(ACT_ENTER,  1'b1, 1,   32'hA5A5_5A5A);
        queue_req(ACT_FINISH, 1'b1, 0,   32'h1234_5678);
        queue_req(ACT_ENTER,  1'b1, 0,   32'h0000_0000);
        queue_req(ACT_ENTER,  1'b1, 1,   32'hA5A5_5A5A);
        queue_req(ACT_ENTER,  1'b1, 1,   32'h5A5A_A5A5);
        queue_req(ACT_FINISH, 1'b1, 2,   32'h0000_0001);
        queue_req(ACT_ENTER,  1'b1, 2,   32'h8000_0000);
        queue_req(ACT_FINISH, 1'b1, 0,   32'h0000_0000);
        queue_req(ACT_FINISH, 1'b1, 1,   32'hA5A5_5A5A);
        queue_req(ACT_FINISH, 1'b1, 255, 32'hFFFF_FFFF);
        queue_req(ACT_ENTER,  1'b1, 255, 32'hFFFF_FFFF);
        queue_req(ACT_ENTER,  1'b0, 3,   32'h0000_0000);
        drain_wait();

        run_phase(RANDOM_BEATS / 3, 25, 57, 1'b1);
        drain_wait();

        send_idle = 57;
        recv_idle = 25;
        flood_table();
        run_phase(RANDOM_BEATS / 3, 57, 25, 1'b0);
        drain_wait();

        run_phase(items_left, 0, 0, 1'b0);
        drain_wait();

        // Let any stray response show up before the verdict is given.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("once_guard_owner_table: match");
        end
        else
        begin
            $display("once_guard_owner_table: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/ogot_pkg.sv
rtl/core/ogot_ctrl.sv
rtl/core/ogot_dp.sv
rtl/core/once_guard_owner_table.sv
test/tb_top.sv
